/* rtl/ordered_dither_requantizer_top_defines.svh */
// Assertion macros for the requantizer.
`ifndef ORDERED_DITHER_REQUANTIZER_TOP_DEFINES_SVH
`define ORDERED_DITHER_REQUANTIZER_TOP_DEFINES_SVH

// Same-cycle implication.
`define ODR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define ODR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

/* rtl/odr_pkg.sv */
`default_nettype none

package odr_pkg;

	localparam int MAX_IN_BITS  = 16;
	localparam int MAX_OUT_BITS = 8;
	localparam int SAMPLE_W     = 16;
	localparam int COORD_W      = 8;
	localparam int LEVEL_W      = 8;
	localparam int IB_W         = 5;
	localparam int OB_W         = 4;
	localparam int CFG_DATA_W   = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int BAYER_LEVELS = 8;
	localparam int THR_W        = 2 * BAYER_LEVELS;
	localparam int LUT_DEPTH    = 256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_BITS   = 2'd0,
		REG_OUT_BITS  = 2'd1,
		REG_DITHER_ON = 2'd2
	} cfg_reg_t;

	typedef logic [1:0] bayer_row_t [2];
	typedef bayer_row_t bayer_mat_t [2];

	localparam bayer_mat_t BAYER_DIGIT = '{'{2'd0, 2'd3}, '{2'd2, 2'd1}};

	typedef logic [LEVEL_W-1:0] gray_lut_t [LUT_DEPTH];

	// Entry (2^k - 2) + h holds floor(h * 255 / (2^k - 1)) for k = 1..7.
	function automatic gray_lut_t build_gray_lut();
		gray_lut_t lut;
		int m;
		int acc;
		int q;
		int idx;
		lut = '{default: '0};
		idx = 0;
		for (int k = 1; k < MAX_OUT_BITS; k++) begin
			m = (1 << k) - 1;
			acc = 0;
			q = 0;
			for (int h = 0; h <= m; h++) begin
				lut[idx] = LEVEL_W'(q);
				idx++;
				acc += 255;
				while (acc >= m) begin
					acc -= m;
					q++;
				end
			end
		end
		return lut;
	endfunction

	localparam gray_lut_t GRAY_LUT = build_gray_lut();

endpackage

`default_nettype wire

/* rtl/ordered_dither_requantizer_top.sv */
// Ordered-dither requantizer. Takes one sample per clock: a transfer happens
// on every edge with start high, and busy stays low. The level and gray result
// of a sample passes the input register and then the result register, and is
// shown on level and gray for the single cycle in which done is high; the
// receiver cannot stall, so it must take every result as it comes. One pass
// through the input register, the threshold/compare logic and the result
// register sets the rate of one sample per clock. Write in_bits, out_bits and
// dither_on only while no result is pending.
`default_nettype none

`include "ordered_dither_requantizer_top_defines.svh"

module ordered_dither_requantizer_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [odr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [odr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [odr_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic [odr_pkg::COORD_W-1:0]    row,
	input  wire logic [odr_pkg::COORD_W-1:0]    column,
	output logic                                done,
	output logic [odr_pkg::LEVEL_W-1:0]         level,
	output logic [odr_pkg::LEVEL_W-1:0]         gray
);
	import odr_pkg::*;

	logic [IB_W-1:0] in_bits_q;
	logic [OB_W-1:0] out_bits_q;
	logic            dither_on_q;

	logic                accept;
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [COORD_W-1:0]  row_s1;
	logic [COORD_W-1:0]  column_s1;

	logic [IB_W-1:0]     ib;
	logic [OB_W-1:0]     ob;
	logic [SAMPLE_W:0]   smp_mask;
	logic [SAMPLE_W-1:0] smp;
	logic [3:0]          dr;
	logic [SAMPLE_W:0]   low_mask;
	logic [SAMPLE_W-1:0] low;
	logic [LEVEL_W:0]    maxlev_w;
	logic [LEVEL_W-1:0]  maxlev;
	logic [3:0]          levels;
	logic [THR_W-1:0]    thr_full;
	logic [4:0]          thr_shift;
	logic [THR_W-1:0]    thr;
	logic [SAMPLE_W:0]   hi;
	logic [LEVEL_W-1:0]  level_c;
	logic [LEVEL_W-1:0]  gray_idx;
	logic [LEVEL_W-1:0]  gray_c;

	logic                done_s2;
	logic [LEVEL_W-1:0]  level_s2;
	logic [LEVEL_W-1:0]  gray_s2;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bits_q   <= IB_W'(8);
			out_bits_q  <= OB_W'(8);
			dither_on_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IN_BITS:   in_bits_q   <= cfg_wdata;
				REG_OUT_BITS:  out_bits_q  <= cfg_wdata[OB_W-1:0];
				REG_DITHER_ON: dither_on_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			row_s1    <= row;
			column_s1 <= column;
		end
	end

	// threshold: level 0 is the most significant base-4 digit
	always_comb begin
		for (int t = 0; t < BAYER_LEVELS; t++) begin
			thr_full[THR_W-1-2*t -: 2] = BAYER_DIGIT[row_s1[t]][column_s1[t]];
		end
	end

	always_comb begin
		if (in_bits_q == '0) begin
			ib = IB_W'(1);
		end else if (in_bits_q > IB_W'(MAX_IN_BITS)) begin
			ib = IB_W'(MAX_IN_BITS);
		end else begin
			ib = in_bits_q;
		end
		if (out_bits_q == '0) begin
			ob = OB_W'(1);
		end else if (out_bits_q > OB_W'(MAX_OUT_BITS)) begin
			ob = OB_W'(MAX_OUT_BITS);
		end else begin
			ob = out_bits_q;
		end

		smp_mask = ((SAMPLE_W+1)'(1) << ib) - (SAMPLE_W+1)'(1);
		smp      = sample_s1 & smp_mask[SAMPLE_W-1:0];
		dr       = (ib > 5'(ob)) ? 4'(ib - 5'(ob)) : 4'd0;
		low_mask = ((SAMPLE_W+1)'(1) << dr) - (SAMPLE_W+1)'(1);
		low      = smp & low_mask[SAMPLE_W-1:0];
		maxlev_w = ((LEVEL_W+1)'(1) << ob) - (LEVEL_W+1)'(1);
		maxlev   = maxlev_w[LEVEL_W-1:0];

		levels    = {1'b0, dr[3:1]} + ((ob == OB_W'(1)) ? 4'd1 : 4'd0);
		thr_shift = 5'(THR_W) - {levels, 1'b0};
		thr       = thr_full >> thr_shift;

		hi = {1'b0, smp >> dr};
		if (dr != '0 && dither_on_q) begin
			if (ob == OB_W'(1)) begin
				hi = (smp >= thr) ? (SAMPLE_W+1)'(1) : '0;
			end else if (low >= thr) begin
				hi = hi + (SAMPLE_W+1)'(1);
			end
		end

		if (hi > (SAMPLE_W+1)'(maxlev)) begin
			level_c = maxlev;
		end else begin
			level_c = hi[LEVEL_W-1:0];
		end

		gray_idx = maxlev + level_c - LEVEL_W'(1);
		if (ob == OB_W'(MAX_OUT_BITS)) begin
			gray_c = level_c;
		end else begin
			gray_c = GRAY_LUT[gray_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			level_s2 <= level_c;
			gray_s2  <= gray_c;
		end
	end

	assign done  = done_s2;
	assign level = level_s2;
	assign gray  = gray_s2;

	`ODR_ASSERT_NEXT(a_done_follows, valid_s1, done)
	`ODR_ASSERT_NEXT(a_no_spurious_done, !valid_s1, !done)
	`ODR_ASSERT_NEXT(a_level_saturated, valid_s1, level <= $past(maxlev))
	`ODR_ASSERT_NEXT(a_gray_full_depth, valid_s1 && ob == OB_W'(MAX_OUT_BITS), gray == level)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
	import odr_pkg::*;

	localparam int QUIET_LIMIT = 500;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] gray;
	} level_pair_t;

	class dither_scoreboard;
		logic [IB_W-1:0] in_bits = 5'd8;
		logic [OB_W-1:0] out_bits = 4'd8;
		logic dither_on = 1'b1;
		level_pair_t pending_levels[$];
		int errors = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_IN_BITS: in_bits = data[IB_W-1:0];
			REG_OUT_BITS: out_bits = data[OB_W-1:0];
			REG_DITHER_ON: dither_on = data[0];
			default: ;
			endcase
		endfunction

		function level_pair_t predict_level(logic [SAMPLE_W-1:0] s, logic [COORD_W-1:0] r,
				logic [COORD_W-1:0] c);
			int unsigned ib, ob, dr, smp, maxlev, hi, nlev, thr;
			level_pair_t res;
			ib = 32'(in_bits);
			ob = 32'(out_bits);
			if (ib < 1)
				ib = 1;
			if (ib > MAX_IN_BITS)
				ib = MAX_IN_BITS;
			if (ob < 1)
				ob = 1;
			if (ob > MAX_OUT_BITS)
				ob = MAX_OUT_BITS;
			smp = 32'(s) & ((32'd1 << ib) - 1);
			dr = (ib > ob) ? ib - ob : 0;
			maxlev = (32'd1 << ob) - 1;
			hi = smp >> dr;
			if (dr != 0 && dither_on) begin
				nlev = dr / 2 + ((ob == 1) ? 1 : 0);
				thr = 0;
				// matrix digit {{0,3},{2,1}}[r][c] equals {r^c, c}
				for (int t = 0; t < nlev; t++)
					thr = thr * 4 + 32'({r[t] ^ c[t], c[t]});
				if (ob == 1)
					hi = (smp >= thr) ? 1 : 0;
				else if ((smp & ((32'd1 << dr) - 1)) >= thr)
					hi++;
			end
			if (hi > maxlev)
				hi = maxlev;
			res.level = 8'(hi);
			res.gray = (ob < MAX_OUT_BITS) ? 8'(hi * 255 / maxlev) : 8'(hi);
			return res;
		endfunction

		function void note_pixel(logic [SAMPLE_W-1:0] s, logic [COORD_W-1:0] r,
				logic [COORD_W-1:0] c);
			pending_levels.push_back(predict_level(s, r, c));
		endfunction

		function void check_level(logic [LEVEL_W-1:0] lvl, logic [LEVEL_W-1:0] gry);
			level_pair_t exp_pair;
			if (pending_levels.size() == 0) begin
				$display("%0t: unexpected result level %0d gray %0d", $time, lvl, gry);
				errors++;
				return;
			end
			exp_pair = pending_levels.pop_front();
			if (lvl !== exp_pair.level) begin
				$display("%0t: level expected %0d actual %0d", $time, exp_pair.level, lvl);
				errors++;
			end
			if (gry !== exp_pair.gray) begin
				$display("%0t: gray expected %0d actual %0d", $time, exp_pair.gray, gry);
				errors++;
			end
		endfunction

		function int pending();
			return pending_levels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic start;
	logic busy;
	logic [SAMPLE_W-1:0] sample;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] column;
	logic done;
	logic [LEVEL_W-1:0] level;
	logic [LEVEL_W-1:0] gray;

	dither_scoreboard sb = new();
	bit idle_on;
	int quiet_cycles;

	ordered_dither_requantizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.sample(sample),
		.row(row),
		.column(column),
		.done(done),
		.level(level),
		.gray(gray)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_pixel(sample, row, column);
			if (done)
				sb.check_level(level, gray);
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_wdata);
			if ((start && !busy) || done || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_pixel(input logic [SAMPLE_W-1:0] s, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c);
		int gap;
		gap = idle_on ? int'($urandom_range(0, 5)) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		row <= r;
		column <= c;
		do @(posedge clk); while (busy);
	endtask

	// hold off until the pipeline has drained
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic set_format(input logic [4:0] ib, input logic [4:0] ob, input logic [4:0] dith);
		drain();
		write_reg(REG_IN_BITS, ib);
		write_reg(REG_OUT_BITS, ob);
		write_reg(REG_DITHER_ON, dith);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		int phase_len;
		int ib_eff;
		logic [4:0] ib, ob;
		logic [SAMPLE_W-1:0] s;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IN_BITS;
		cfg_wdata = '0;
		start = 1'b0;
		sample = '0;
		row = '0;
		column = '0;
		idle_on = 1'b0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset format: 8 in, 8 out, nothing dropped
		send_pixel(16'h0000, 8'd0, 8'd0);
		send_pixel(16'hFFFF, 8'd255, 8'd255);
		send_pixel(16'h00AB, 8'd1, 8'd2);
		// one-bit output compares the whole sample
		set_format(5'd16, 5'd1, 5'd1);
		send_pixel(16'h0000, 8'd0, 8'd0);
		send_pixel(16'hFFFF, 8'd255, 8'd255);
		send_pixel(16'h8000, 8'd0, 8'd0);
		send_pixel(16'h7FFF, 8'd255, 8'd255);
		// single dropped bit: zero threshold, always increments
		set_format(5'd9, 5'd8, 5'd1);
		send_pixel(16'h01FF, 8'd0, 8'd0);
		send_pixel(16'h0100, 8'd3, 8'd5);
		// fewer input bits than output bits
		set_format(5'd4, 5'd6, 5'd1);
		send_pixel(16'hFFFF, 8'd170, 8'd85);
		send_pixel(16'h000A, 8'd0, 8'd255);
		// out of range registers get clamped
		set_format(5'd0, 5'd0, 5'd1);
		send_pixel(16'hFFFF, 8'd1, 8'd0);
		send_pixel(16'h0000, 8'd0, 8'd1);
		set_format(5'd31, 5'd15, 5'd0);
		send_pixel(16'hFFFF, 8'd255, 8'd0);
		send_pixel(16'h1234, 8'd0, 8'd255);
		set_format(5'd12, 5'd2, 5'd1);
		send_pixel(16'h0FFF, 8'd255, 8'd255);
		send_pixel(16'h0800, 8'd170, 8'd85);
		send_pixel(16'h07FF, 8'd85, 8'd170);
		set_format(5'd10, 5'd4, 5'd0);
		send_pixel(16'h03FF, 8'd7, 8'd9);
		send_pixel(16'h0200, 8'd128, 8'd64);

		sent = 0;
		while (sent < 1600) begin
			if ($urandom_range(0, 9) < 7) begin
				ob = 5'($urandom_range(1, 8));
				if (ob == 1)
					ib = 5'($urandom_range(1, 16));
				else
					ib = 5'(32'(ob) + 2 * $urandom_range(0, (16 - 32'(ob)) / 2));
			end else begin
				ib = 5'($urandom_range(0, 31));
				ob = 5'($urandom_range(0, 15));
			end
			ib_eff = (ib < 1) ? 1 : (ib > 16) ? 16 : int'(ib);
			set_format(ib, {1'($urandom_range(0, 1)), ob[3:0]},
				{4'($urandom_range(0, 15)), 1'($urandom_range(0, 3) != 0)});
			idle_on = $urandom_range(0, 3) != 0;
			phase_len = int'($urandom_range(20, 60));
			repeat (phase_len) begin
				case ($urandom_range(0, 3))
				0: s = 16'($urandom_range(0, 65535));
				1, 2: s = 16'($urandom_range(0, 65535) & ((32'd1 << ib_eff) - 1));
				default: s = $urandom_range(0, 1) ? (16'hFFFF >> $urandom_range(0, 15))
					: (16'h0001 << $urandom_range(0, 15));
				endcase
				send_pixel(s, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				sent++;
			end
		end

		drain();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

/* ordered_dither_requantizer_top.f */
+incdir+rtl
rtl/odr_pkg.sv
rtl/ordered_dither_requantizer_top.sv
tb/sv/tb.sv
